// ----- sv/qrs_pkg.sv -----
// qrs_pkg: shared widths, root-kind codes, channel payload types and
// pipeline control type for the quadratic root solver. No dependencies.
package qrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DISC_BITS = 2 * WORD_BITS + 2;     // |b*b| + |4ac| fits here
    localparam int ROOT_BITS = WORD_BITS + 1;         // floor sqrt of DISC
    localparam int NUM_BITS  = WORD_BITS + 2;         // |b| + sqrt magnitude
    localparam int SNUM_BITS = NUM_BITS + FRAC_BITS;  // shifted dividend
    localparam int DEN_BITS  = WORD_BITS + 1;         // |2a| or |b|
    localparam int SQRT_STEPS = ROOT_BITS;
    localparam int DIV_STEPS  = SNUM_BITS;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_ALL  = 2'd3;

    localparam logic [WORD_BITS-1:0] TOL_RESET = 32'd4295;

    typedef logic [WORD_BITS-1:0] word_t;

    // input transaction: signed Q16.16 coefficients
    typedef struct packed {
        word_t coef_a;
        word_t coef_b;
        word_t coef_c;
    } coefs_t;

    // result transaction
    typedef struct packed {
        logic [1:0] root_kind;
        word_t      root_low;
        word_t      root_high;
        logic       saturated;
    } roots_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                two;     // two roots need the square root
        logic                nb;      // sign of -b (of -c when a is zero)
        logic [WORD_BITS-1:0] bmag;
        logic                dneg;    // sign of the denominator
        logic [DEN_BITS-1:0] den;
    } ctl_t;

endpackage

// ----- sv/qrs_if.sv -----
// qrs_if: valid/ready channel carrying one typed payload.
// Depends on qrs_pkg for default payload width.
interface qrs_if #(parameter type payload_t = logic [qrs_pkg::WORD_BITS-1:0]);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/quadratic_root_solver.sv -----
// Quadratic root solver: one fully pipelined datapath. A transaction on in_ch
// (coef_a, coef_b, coef_c, signed Q16.16) yields exactly one transaction on
// out_ch (root_kind, root_low, root_high, saturated), in order. One item enters
// every clock cycle while the output is not stalled; the stages are the product,
// discriminant and classify stages, one stage per bit of the 33-bit floor square
// root, the numerator stage, one stage per quotient bit of the two parallel
// restoring dividers, and the sign/saturate and order stages.
// Every stage holds while the output register is full and not taken, so a stall
// freezes the whole pipe. disc_tolerance (reset 4295, unsigned Q0.32) is
// written on cfg_ch; a discriminant from zero up to it gives one root -b/(2a).
module quadratic_root_solver (
    input  logic clk,
    input  logic rst_n,
    qrs_if.sink   in_ch,
    qrs_if.sink   cfg_ch,
    qrs_if.source out_ch
);
    localparam int W  = qrs_pkg::WORD_BITS;
    localparam int DB = qrs_pkg::DISC_BITS;
    localparam int RB = qrs_pkg::ROOT_BITS;
    localparam int NB = qrs_pkg::NUM_BITS;
    localparam int SB = qrs_pkg::SNUM_BITS;
    localparam int EB = qrs_pkg::DEN_BITS;
    localparam int NS = qrs_pkg::SQRT_STEPS;
    localparam int ND = qrs_pkg::DIV_STEPS;
    localparam logic [qrs_pkg::FRAC_BITS-1:0] FRAC_ZERO = '0;

    // advance enable for the whole pipe
    logic adv;
    assign adv = out_ch.ready || !out_ch.valid;
    assign in_ch.ready  = adv;
    assign cfg_ch.ready = 1'b1;

    logic [W-1:0] tol_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= qrs_pkg::TOL_RESET;
        else if (cfg_ch.valid && cfg_ch.ready)
            tol_reg <= cfg_ch.data;
    end

    // ---- stage 1: magnitudes and products ----
    logic [W-1:0] am, bm, cm;
    logic an, bn, cn;
    assign an = in_ch.data.coef_a[W-1];
    assign bn = in_ch.data.coef_b[W-1];
    assign cn = in_ch.data.coef_c[W-1];
    assign am = an ? W'(-in_ch.data.coef_a) : in_ch.data.coef_a;
    assign bm = bn ? W'(-in_ch.data.coef_b) : in_ch.data.coef_b;
    assign cm = cn ? W'(-in_ch.data.coef_c) : in_ch.data.coef_c;

    logic                v1_reg;
    logic [2*W-1:0]      bb_reg, ac_reg;
    logic                an1_reg, bn1_reg, cn1_reg;
    logic [W-1:0]        am1_reg, bm1_reg, cm1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_ch.valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bb_reg  <= bm * bm;
            ac_reg  <= am * cm;
            an1_reg <= an; bn1_reg <= bn; cn1_reg <= cn;
            am1_reg <= am; bm1_reg <= bm; cm1_reg <= cm;
        end
    end

    // ---- stage 2: discriminant ----
    logic [DB-1:0] bbx, acx, d_sum, d_dif, d_rev;
    logic          acneg;
    assign bbx   = DB'(bb_reg);
    assign acx   = DB'(ac_reg) << 2;
    assign acneg = (an1_reg != cn1_reg) && (cm1_reg != '0);
    assign d_sum = bbx + acx;
    assign d_dif = bbx - acx;
    assign d_rev = acx - bbx;

    logic          v2_reg, dneg2_reg, an2_reg, bn2_reg, cn2_reg;
    logic [DB-1:0] d2_reg;
    logic [W-1:0]  am2_reg, bm2_reg, cm2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dneg2_reg <= !acneg && (bbx < acx);
            d2_reg    <= acneg ? d_sum : ((bbx >= acx) ? d_dif : d_rev);
            an2_reg <= an1_reg; bn2_reg <= bn1_reg; cn2_reg <= cn1_reg;
            am2_reg <= am1_reg; bm2_reg <= bm1_reg; cm2_reg <= cm1_reg;
        end
    end

    // ---- stage 3: classify ----
    qrs_pkg::ctl_t c_next;
    always_comb
    begin
        c_next      = '0;
        c_next.bmag = bm2_reg;
        if (am2_reg == '0)
        begin
            if (bm2_reg == '0)
                c_next.kind = (cm2_reg == '0) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
            else
            begin
                c_next.kind  = qrs_pkg::KIND_ONE;
                c_next.nb    = !cn2_reg && (cm2_reg != '0);
                c_next.bmag  = cm2_reg;
                c_next.dneg  = bn2_reg;
                c_next.den   = EB'(bm2_reg);
            end
        end
        else
        begin
            c_next.nb   = !bn2_reg && (bm2_reg != '0);
            c_next.dneg = an2_reg;
            c_next.den  = {am2_reg, 1'b0};
            if (dneg2_reg)
                c_next.kind = qrs_pkg::KIND_NONE;
            else if (d2_reg <= DB'(tol_reg))
                c_next.kind = qrs_pkg::KIND_ONE;
            else
            begin
                c_next.kind = qrs_pkg::KIND_TWO;
                c_next.two  = 1'b1;
            end
        end
    end

    // ---- square root: one result bit per stage ----
    logic          sv_reg  [NS+1];
    qrs_pkg::ctl_t sc_reg  [NS+1];
    logic [DB-1:0] sd_reg  [NS+1];
    logic [RB-1:0] sr_reg  [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (adv)
            sv_reg[0] <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_reg[0] <= c_next;
            sd_reg[0] <= d2_reg;
            sr_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        logic [RB-1:0]   cand;
        logic [2*RB-1:0] sq;
        assign cand = sr_reg[k] | (RB'(1) << (NS - 1 - k));
        assign sq   = cand * cand;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else if (adv)
                sv_reg[k+1] <= sv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sc_reg[k+1] <= sc_reg[k];
                sd_reg[k+1] <= sd_reg[k];
                sr_reg[k+1] <= (sq <= (2*RB)'(sd_reg[k])) ? cand : sr_reg[k];
            end
        end
    end

    // ---- numerators: -b -/+ sqrt in sign-magnitude ----
    qrs_pkg::ctl_t cs;
    logic [NB-1:0] bx, sx, m1, m2;
    logic          n1, n2;
    assign cs = sc_reg[NS];
    assign bx = NB'(cs.bmag);
    assign sx = cs.two ? NB'(sr_reg[NS]) : '0;
    always_comb
    begin
        // first: nb + (negative s)
        if (cs.nb)
        begin
            m1 = bx + sx; n1 = 1'b1;
        end
        else if (bx >= sx)
        begin
            m1 = bx - sx; n1 = 1'b0;
        end
        else
        begin
            m1 = sx - bx; n1 = 1'b1;
        end
        if (m1 == '0)
            n1 = 1'b0;
        // second: nb + (positive s)
        if (!cs.nb)
        begin
            m2 = bx + sx; n2 = 1'b0;
        end
        else if (bx >= sx)
        begin
            m2 = bx - sx; n2 = 1'b1;
        end
        else
        begin
            m2 = sx - bx; n2 = 1'b0;
        end
        if (m2 == '0)
            n2 = 1'b0;
    end

    // ---- dividers: one quotient bit per stage, two in parallel ----
    logic          dv_reg [ND+1];
    qrs_pkg::ctl_t dc_reg [ND+1];
    logic          dn1_reg [ND+1];
    logic          dn2_reg [ND+1];
    logic [SB-1:0] dq1_reg [ND+1];
    logic [SB-1:0] dq2_reg [ND+1];
    logic [EB:0]   dr1_reg [ND+1];
    logic [EB:0]   dr2_reg [ND+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= sv_reg[NS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dc_reg[0]  <= cs;
            dn1_reg[0] <= n1;
            dn2_reg[0] <= n2;
            dq1_reg[0] <= {m1, FRAC_ZERO};
            dq2_reg[0] <= {m2, FRAC_ZERO};
            dr1_reg[0] <= '0;
            dr2_reg[0] <= '0;
        end
    end

    // dq holds the remaining dividend bits shifted up and the quotient shifted in
    for (genvar k = 0; k < ND; k++)
    begin : g_div
        logic [EB:0] t1, t2;
        logic        g1, g2;
        assign t1 = {dr1_reg[k][EB-1:0], dq1_reg[k][SB-1]};
        assign t2 = {dr2_reg[k][EB-1:0], dq2_reg[k][SB-1]};
        assign g1 = t1 >= {1'b0, dc_reg[k].den};
        assign g2 = t2 >= {1'b0, dc_reg[k].den};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (adv)
                dv_reg[k+1] <= dv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dc_reg[k+1]  <= dc_reg[k];
                dn1_reg[k+1] <= dn1_reg[k];
                dn2_reg[k+1] <= dn2_reg[k];
                dr1_reg[k+1] <= g1 ? (t1 - {1'b0, dc_reg[k].den}) : t1;
                dr2_reg[k+1] <= g2 ? (t2 - {1'b0, dc_reg[k].den}) : t2;
                dq1_reg[k+1] <= {dq1_reg[k][SB-2:0], g1};
                dq2_reg[k+1] <= {dq2_reg[k][SB-2:0], g2};
            end
        end
    end

    // ---- sign and saturate ----
    qrs_pkg::ctl_t ce;
    logic          neg1, neg2, sat1, sat2;
    logic [SB-1:0] lim1, lim2;
    logic [W-1:0]  r1, r2;
    assign ce   = dc_reg[ND];
    assign neg1 = dn1_reg[ND] != ce.dneg;
    assign neg2 = dn2_reg[ND] != ce.dneg;
    assign lim1 = neg1 ? (SB'(1) << (W - 1)) : ((SB'(1) << (W - 1)) - SB'(1));
    assign lim2 = neg2 ? (SB'(1) << (W - 1)) : ((SB'(1) << (W - 1)) - SB'(1));
    assign sat1 = dq1_reg[ND] > lim1;
    assign sat2 = dq2_reg[ND] > lim2;
    always_comb
    begin
        r1 = sat1 ? W'(lim1) : W'(dq1_reg[ND]);
        r2 = sat2 ? W'(lim2) : W'(dq2_reg[ND]);
        if (neg1) r1 = W'(-r1);
        if (neg2) r2 = W'(-r2);
    end

    logic         fv_reg, fs1_reg, fs2_reg;
    logic [1:0]   fk_reg;
    logic [W-1:0] f1_reg, f2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (adv)
            fv_reg <= dv_reg[ND];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fk_reg  <= ce.kind;
            f1_reg  <= r1;
            f2_reg  <= r2;
            fs1_reg <= sat1;
            fs2_reg <= sat2;
        end
    end

    // ---- order roots into the output register ----
    logic [W-1:0] lo_next, hi_next;
    logic         sat_next;
    always_comb
    begin
        lo_next  = '0;
        hi_next  = '0;
        sat_next = 1'b0;
        case (fk_reg)
            qrs_pkg::KIND_ONE:
            begin
                lo_next  = f1_reg;
                sat_next = fs1_reg;
            end
            qrs_pkg::KIND_TWO:
            begin
                sat_next = fs1_reg || fs2_reg;
                if ($signed(f1_reg) > $signed(f2_reg))
                begin
                    lo_next = f2_reg; hi_next = f1_reg;
                end
                else
                begin
                    lo_next = f1_reg; hi_next = f2_reg;
                end
            end
            default:
            begin
                lo_next = '0;
            end
        endcase
    end

    logic         ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= fv_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ch.data.root_kind <= fk_reg;
            out_ch.data.root_low  <= lo_next;
            out_ch.data.root_high <= hi_next;
            out_ch.data.saturated <= sat_next;
        end
    end
    assign out_ch.valid = ov_reg;

`ifndef NO_ASSERTIONS
    // a held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    // unused root fields are zero
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.data.root_kind != qrs_pkg::KIND_TWO)
        |-> out_ch.data.root_high == '0)
        else $error("root_high set without two roots");
    // two roots come out ordered
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.data.root_kind == qrs_pkg::KIND_TWO)
        |-> $signed(out_ch.data.root_low) <= $signed(out_ch.data.root_high))
        else $error("roots out of order");
`endif

endmodule
